// ===== hdl/ist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types for the interpolation search table.
// ----------------------------------------------------------------------------
package ist_pkg;

    // Input selector carried in s_tuser
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Fixed field widths
    localparam int INDEX_W = 10;
    localparam int REF_W   = 10;
    localparam int COUNT_W = 11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_RD_L,
        ST_RD_R,
        ST_EVAL,
        ST_DIV,
        ST_RD_M,
        ST_CMP,
        ST_RD_FIN,
        ST_FIN,
        ST_DONE
    } ist_state_t;

endpackage

// ===== hdl/interpolation_search_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolation_search_table
// Sorted key table with an interpolation search sequencer.
// ----------------------------------------------------------------------------
// Load words (s_tuser = 0) write one key and reference into the table RAM
// while the sequencer stays idle; a load whose index is not below TABLE_DEPTH
// is dropped and gives no result. Search words (s_tuser = 1) produce exactly
// one result word. Each probe of a search runs through a bound check, two
// bound reads, an evaluation, the bit-serial scaler (one index bit per cycle),
// a probe read and a compare. A probe whose bound keys are equal or
// descending, or whose key sits at or above the right bound key, skips the
// scaler. The sorted table must hold ascending keys in entries 0 to
// entry_count-1; only written entries may be searched.
// A finished result waits in the output register while loads are accepted.
// ----------------------------------------------------------------------------
module interpolation_search_table
    import ist_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 34,
    localparam int S_DATA_W   = ((INDEX_W + KEY_WIDTH + REF_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration: entry_count
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    // Input words
    input  logic                s_tvalid,
    output logic                s_tready,
    // entry_index, key, record_ref (from bit 0 up), zero padded
    input  logic [S_DATA_W-1:0] s_tdata,
    // func
    input  logic                s_tuser,
    // Result words
    output logic                m_tvalid,
    input  logic                m_tready,
    // position, match_ref (from bit 0 up), zero padded
    output logic [23:0]         m_tdata,
    // found
    output logic                m_tuser
);

    localparam int IDXW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW  = IDXW + 1;
    localparam int WORDW = KEY_WIDTH + REF_W;

    ist_state_t state_reg, state_next;

    logic [COUNT_W-1:0]   count_reg;
    logic [CNTW-1:0]      cnt_eff;
    logic [CNTW-1:0]      l_reg;
    logic [IDXW-1:0]      r_reg;
    logic [IDXW-1:0]      m_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] kl_reg;

    logic                 res_found_reg;
    logic [INDEX_W-1:0]   res_pos_reg;
    logic [REF_W-1:0]     res_ref_reg;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [INDEX_W-1:0]   out_pos_reg;
    logic [REF_W-1:0]     out_ref_reg;

    // Input fields
    logic [INDEX_W-1:0]   in_index;
    logic [KEY_WIDTH-1:0] in_key;
    logic [REF_W-1:0]     in_ref;
    logic                 in_accept;
    logic                 load_ok;

    // RAM port
    logic                 ram_we;
    logic [IDXW-1:0]      ram_addr;
    logic [WORDW-1:0]     ram_rdata;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [REF_W-1:0]     rd_ref;

    // Probe evaluation
    logic [KEY_WIDTH-1:0] kc, num, den;
    logic                 bounds_flat;
    logic                 num_full;
    logic [IDXW-1:0]      span;
    logic                 div_start;
    logic                 div_done;
    logic [IDXW-1:0]      div_q;
    logic                 out_free;

    assign in_index  = s_tdata[INDEX_W-1:0];
    assign in_key    = s_tdata[INDEX_W+KEY_WIDTH-1:INDEX_W];
    assign in_ref    = s_tdata[INDEX_W+KEY_WIDTH+REF_W-1:INDEX_W+KEY_WIDTH];
    assign in_accept = s_tvalid && s_tready;
    assign load_ok   = (32'(in_index) < 32'(TABLE_DEPTH));
    assign rd_key    = ram_rdata[KEY_WIDTH-1:0];
    assign rd_ref    = ram_rdata[WORDW-1:KEY_WIDTH];
    assign out_free  = !out_valid_reg || m_tready;

    // Clamp the count to the table depth
    assign cnt_eff = (32'(count_reg) > 32'(TABLE_DEPTH)) ? CNTW'(TABLE_DEPTH)
                                                         : CNTW'(count_reg);

    // Clamp the key into the bound keys and form the interpolation terms
    always_comb begin
        if (key_reg < kl_reg) begin
            kc = kl_reg;
        end else if (key_reg > rd_key) begin
            kc = rd_key;
        end else begin
            kc = key_reg;
        end
        num         = kc - kl_reg;
        den         = rd_key - kl_reg;
        bounds_flat = (rd_key <= kl_reg);
        num_full    = (num == den);
        span        = r_reg - l_reg[IDXW-1:0];
    end

    ist_ram #(
        .WIDTH (WORDW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({in_ref, in_key}),
        .rdata (ram_rdata)
    );

    ist_div #(
        .KEY_WIDTH (KEY_WIDTH),
        .IDXW      (IDXW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .span    (span),
        .num     (num),
        .den     (den),
        .done    (div_done),
        .q       (div_q)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_tuser == FUNC_SEARCH) begin
                    state_next = (cnt_eff == '0) ? ST_DONE : ST_CHK;
                end
            end
            ST_CHK: begin
                if (l_reg < {1'b0, r_reg}) begin
                    state_next = ST_RD_L;
                end else if (l_reg < cnt_eff) begin
                    state_next = ST_RD_FIN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RD_L:   state_next = ST_RD_R;
            ST_RD_R:   state_next = ST_EVAL;
            ST_EVAL: begin
                state_next = (bounds_flat || num_full) ? ST_RD_M : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_RD_M;
                end
            end
            ST_RD_M:   state_next = ST_CMP;
            ST_CMP: begin
                if (rd_key == key_reg) begin
                    state_next = ST_DONE;
                end else if (rd_key > key_reg && m_reg == l_reg[IDXW-1:0]) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CHK;
                end
            end
            ST_RD_FIN: state_next = ST_FIN;
            ST_FIN:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = '0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_we   = s_tvalid && s_tuser == FUNC_LOAD && load_ok;
                ram_addr = IDXW'(in_index);
            end
            ST_RD_L:   ram_addr = l_reg[IDXW-1:0];
            ST_RD_R:   ram_addr = r_reg;
            ST_EVAL:   div_start = !(bounds_flat || num_full);
            ST_RD_M:   ram_addr = m_reg;
            ST_RD_FIN: ram_addr = l_reg[IDXW-1:0];
            default: begin
                ram_addr = '0;
            end
        endcase
    end

    // Search datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                key_reg       <= in_key;
                l_reg         <= '0;
                r_reg         <= IDXW'(cnt_eff - 1'b1);
                res_found_reg <= 1'b0;
                res_pos_reg   <= '0;
                res_ref_reg   <= '0;
            end
            ST_RD_R: kl_reg <= rd_key;
            ST_EVAL: begin
                if (bounds_flat) begin
                    m_reg <= l_reg[IDXW-1:0];
                end else if (num_full) begin
                    m_reg <= r_reg;
                end
            end
            ST_DIV: begin
                m_reg <= l_reg[IDXW-1:0] + div_q;
            end
            ST_CMP: begin
                if (rd_key == key_reg) begin
                    res_found_reg <= 1'b1;
                    res_pos_reg   <= INDEX_W'(m_reg);
                    res_ref_reg   <= rd_ref;
                end else if (rd_key < key_reg) begin
                    l_reg <= CNTW'(m_reg) + 1'b1;
                end else if (m_reg != l_reg[IDXW-1:0]) begin
                    r_reg <= m_reg - 1'b1;
                end
            end
            ST_FIN: begin
                if (rd_key == key_reg) begin
                    res_found_reg <= 1'b1;
                    res_pos_reg   <= INDEX_W'(l_reg);
                    res_ref_reg   <= rd_ref;
                end
            end
            default: begin
                m_reg <= m_reg;
            end
        endcase
    end

    // Control registers and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_pos_reg;
            out_ref_reg   <= res_ref_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_ref_reg, out_pos_reg};
    assign m_tuser  = out_found_reg;

endmodule

// ===== hdl/ist_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/ist_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_div
// Bit-serial scaler: q = floor(span * num / den), one bit of span per cycle.
// ----------------------------------------------------------------------------
module ist_div
    import ist_pkg::*;
#(
    parameter int KEY_WIDTH = 34,
    parameter int IDXW      = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [IDXW-1:0]      span,
    input  logic [KEY_WIDTH-1:0] num,
    input  logic [KEY_WIDTH-1:0] den,
    output logic                 done,
    output logic [IDXW-1:0]      q
);

    logic [IDXW-1:0]      step_reg;
    logic [IDXW-1:0]      span_reg;
    logic [IDXW-1:0]      q_reg;
    logic [KEY_WIDTH-1:0] num_reg;
    logic [KEY_WIDTH-1:0] den_reg;
    logic [KEY_WIDTH-1:0] rem_reg;
    logic                 busy_reg;

    logic [KEY_WIDTH:0]   s1, s2;
    logic                 c1, c2;
    logic [KEY_WIDTH-1:0] r1, r2;
    logic [IDXW-1:0]      q_next;

    // Double the remainder mod den, then add num mod den when the span bit is set
    always_comb begin
        s1 = {1'b0, rem_reg} + {1'b0, rem_reg};
        c1 = (s1 >= {1'b0, den_reg});
        r1 = c1 ? KEY_WIDTH'(s1 - {1'b0, den_reg}) : s1[KEY_WIDTH-1:0];
        s2 = {1'b0, r1} + {1'b0, num_reg};
        c2 = |(span_reg & step_reg) && (s2 >= {1'b0, den_reg});
        if (|(span_reg & step_reg)) begin
            r2 = c2 ? KEY_WIDTH'(s2 - {1'b0, den_reg}) : s2[KEY_WIDTH-1:0];
        end else begin
            r2 = r1;
        end
        q_next = IDXW'({q_reg, 1'b0} + {{IDXW{1'b0}}, c1} + {{IDXW{1'b0}}, c2});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg[0]) begin
                busy_reg <= 1'b0;
                done     <= 1'b1;
            end
        end
        if (start) begin
            step_reg <= {1'b1, {(IDXW-1){1'b0}}} ;
            span_reg <= span;
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            q_reg    <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg >> 1;
            rem_reg  <= r2;
            q_reg    <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== hdl/ist_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_checker
// Port-level assertions for the interpolation search table.
// ----------------------------------------------------------------------------
module ist_checker
    import ist_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // A search occupies the sequencer: no word taken in the next cycle
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == FUNC_SEARCH |=> !s_tready)
        else $error("input accepted right after a search");

    // A miss reports zero position and reference
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 24'd0)
        else $error("miss with nonzero payload");

endmodule

bind interpolation_search_table ist_checker u_ist_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
